/* src/next_permutation_generator_defines.svh */
// Assertion macros for the next permutation generator.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef NEXT_PERMUTATION_GENERATOR_DEFINES_SVH
`define NEXT_PERMUTATION_GENERATOR_DEFINES_SVH
`ifndef ASSERT_OFF
// clocked check, gated off while reset is high
`define NPG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check without reset gating
`define NPG_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NPG_ASSERT(lbl, clk, rst, prop, msg)
`define NPG_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

/* src/npg_pkg.sv */
// Shared types and constants of the next permutation generator.
// No dependencies; imported by npg_elem_mem, npg_engine and the top level.
package npg_pkg;

   localparam int MAX_ORDER_DEFAULT = 8;
   localparam int ELEM_BITS_DEFAULT = 4;
   localparam int PACK_W            = 32;
   localparam int ORDER_W           = 4;

   localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd8;

   localparam logic [1:0] CMD_RESTART = 2'd0;
   localparam logic [1:0] CMD_LOAD    = 2'd1;
   localparam logic [1:0] CMD_ADVANCE = 2'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [2:0] index;
      logic [3:0] value;
   } npg_req_type;

   typedef struct packed {
      logic [PACK_W-1:0] perm_packed;
      logic              wrapped;
   } npg_rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } npg_mem_ctl_type;

endpackage

/* src/npg_elem_mem.sv */
// Element store: one write port, one registered read port, per-entry valid bits.
// Depends on npg_pkg (npg_mem_ctl_type).
module npg_elem_mem
   import npg_pkg::*;
#(
   parameter int  DEPTH = MAX_ORDER_DEFAULT,
   parameter int  EW    = ELEM_BITS_DEFAULT,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic            clock,
   input  logic            reset,
   input  npg_mem_ctl_type ctl,
   input  logic [AW-1:0]   raddr,
   input  logic [AW-1:0]   waddr,
   input  logic [EW-1:0]   wdata,
   output logic [EW-1:0]   rdata
);

   logic [EW-1:0]    elem_ram [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [EW-1:0]    rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         elem_ram[waddr] <= wdata;
      end
   end

   // unwritten entries read as identity
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   // write-first forwarding on a same-address collision
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         if (ctl.wr_en && (waddr == raddr)) begin
            rdata_ff <= wdata;
         end else if (valid_ff[raddr]) begin
            rdata_ff <= elem_ram[raddr];
         end else begin
            rdata_ff <= EW'(raddr);
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* src/npg_engine.sv */
// Command sequencer: scan, reverse, search, swap and pack passes over the element store.
// Depends on npg_pkg, npg_elem_mem and next_permutation_generator_defines.svh.
`include "next_permutation_generator_defines.svh"
module npg_engine
   import npg_pkg::*;
#(
   parameter int  MAX_ORDER = MAX_ORDER_DEFAULT,
   parameter int  ELEM_BITS = ELEM_BITS_DEFAULT,
   localparam int AW        = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
   localparam int CW        = $clog2(MAX_ORDER + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  npg_req_type   req,
   input  logic [CW-1:0] n,
   output logic          busy,
   output logic          rsp_valid,
   output npg_rsp_type   rsp
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SCAN      = 4'd1;
   localparam logic [3:0] S_REV_RD_LO = 4'd2;
   localparam logic [3:0] S_REV_RD_HI = 4'd3;
   localparam logic [3:0] S_REV_WR_LO = 4'd4;
   localparam logic [3:0] S_REV_WR_HI = 4'd5;
   localparam logic [3:0] S_SRCH_L    = 4'd6;
   localparam logic [3:0] S_SRCH      = 4'd7;
   localparam logic [3:0] S_SWAP_A    = 4'd8;
   localparam logic [3:0] S_SWAP_B    = 4'd9;
   localparam logic [3:0] S_PACK      = 4'd10;

   logic [3:0]           state_ff, state_in;
   logic [CW-1:0]        ptr_ff, ptr_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [AW-1:0]        rd_addr_ff, rd_addr_in;
   logic [AW-1:0]        pivot_ff, pivot_in;
   logic                 found_ff, found_in;
   logic [ELEM_BITS-1:0] prev_ff, prev_in;
   logic [AW-1:0]        lo_ff, lo_in;
   logic [AW-1:0]        hi_ff, hi_in;
   logic [ELEM_BITS-1:0] tmp_ff, tmp_in;
   logic                 best_ok_ff, best_ok_in;
   logic [AW-1:0]        best_ff, best_in;
   logic [ELEM_BITS-1:0] bestval_ff, bestval_in;
   logic                 wrap_ff, wrap_in;
   logic [PACK_W-1:0]    packed_ff, packed_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   npg_rsp_type          rsp_ff, rsp_in;

   npg_mem_ctl_type      ctl;
   logic [AW-1:0]        raddr;
   logic [AW-1:0]        waddr;
   logic [ELEM_BITS-1:0] wdata;
   logic [ELEM_BITS-1:0] rdata;

   logic [AW-1:0]        last_addr;
   logic                 rd_last;
   logic                 issue;
   logic [PACK_W-1:0]    pack_add;

   npg_elem_mem #(
      .DEPTH (MAX_ORDER),
      .EW    (ELEM_BITS)
   ) u_mem (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .raddr (raddr),
      .waddr (waddr),
      .wdata (wdata),
      .rdata (rdata)
   );

   assign last_addr = AW'(n - CW'(1));
   assign rd_last   = rd_vld_ff && (rd_addr_ff == last_addr);
   assign issue     = (ptr_ff != n);
   assign pack_add  = PACK_W'(rdata) << (int'(rd_addr_ff) * ELEM_BITS);
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      pivot_in     = pivot_ff;
      found_in     = found_ff;
      prev_in      = prev_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      tmp_in       = tmp_ff;
      best_ok_in   = best_ok_ff;
      best_in      = best_ff;
      bestval_in   = bestval_ff;
      wrap_in      = wrap_ff;
      packed_in    = packed_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ctl          = '0;
      raddr        = AW'(ptr_ff);
      waddr        = '0;
      wdata        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               wrap_in   = 1'b0;
               ptr_in    = '0;
               packed_in = '0;
               found_in  = 1'b0;
               state_in  = S_PACK;
               case (req.cmd)
                  CMD_RESTART: begin
                     ctl.clear = 1'b1;
                  end
                  CMD_LOAD: begin
                     if (int'(req.index) < MAX_ORDER) begin
                        ctl.wr_en = 1'b1;
                        waddr     = AW'(req.index);
                        wdata     = ELEM_BITS'(req.value);
                     end
                  end
                  CMD_ADVANCE: begin
                     if (n == CW'(1)) begin
                        wrap_in = 1'b1;   // single element has no ascent
                     end else if (n != '0) begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_PACK;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (issue) begin
               ctl.rd_en = 1'b1;
               ptr_in    = ptr_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               if ((rd_addr_ff != '0) && (prev_ff < rdata)) begin
                  pivot_in = rd_addr_ff - AW'(1);
                  found_in = 1'b1;
               end
               prev_in = rdata;
               if (rd_last) begin
                  lo_in    = found_in ? (pivot_in + AW'(1)) : '0;
                  hi_in    = last_addr;
                  state_in = S_REV_RD_LO;
               end
            end
         end

         S_REV_RD_LO: begin
            if (lo_ff < hi_ff) begin
               ctl.rd_en = 1'b1;
               raddr     = lo_ff;
               state_in  = S_REV_RD_HI;
            end else if (found_ff) begin
               state_in = S_SRCH_L;
            end else begin
               wrap_in   = 1'b1;
               ptr_in    = '0;
               packed_in = '0;
               state_in  = S_PACK;
            end
         end

         S_REV_RD_HI: begin
            ctl.rd_en = 1'b1;
            raddr     = hi_ff;
            tmp_in    = rdata;
            state_in  = S_REV_WR_LO;
         end

         S_REV_WR_LO: begin
            ctl.wr_en = 1'b1;
            waddr     = lo_ff;
            wdata     = rdata;
            state_in  = S_REV_WR_HI;
         end

         S_REV_WR_HI: begin
            ctl.wr_en = 1'b1;
            waddr     = hi_ff;
            wdata     = tmp_ff;
            lo_in     = lo_ff + AW'(1);
            hi_in     = hi_ff - AW'(1);
            state_in  = S_REV_RD_LO;
         end

         S_SRCH_L: begin
            ctl.rd_en  = 1'b1;
            raddr      = pivot_ff;
            ptr_in     = CW'(pivot_ff) + CW'(1);
            best_ok_in = 1'b0;
            state_in   = S_SRCH;
         end

         S_SRCH: begin
            if (issue) begin
               ctl.rd_en = 1'b1;
               ptr_in    = ptr_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               if (rd_addr_ff == pivot_ff) begin
                  tmp_in = rdata;   // pivot value
               end else if ((rdata > tmp_ff) && (!best_ok_ff || (rdata < bestval_ff))) begin
                  best_ok_in = 1'b1;
                  bestval_in = rdata;
                  best_in    = rd_addr_ff;
               end
               if (rd_last) begin
                  state_in = S_SWAP_A;
               end
            end
         end

         S_SWAP_A: begin
            if (best_ok_ff) begin
               ctl.wr_en = 1'b1;
               waddr     = best_ff;
               wdata     = tmp_ff;
               state_in  = S_SWAP_B;
            end else begin
               ptr_in    = '0;
               packed_in = '0;
               state_in  = S_PACK;
            end
         end

         S_SWAP_B: begin
            ctl.wr_en = 1'b1;
            waddr     = pivot_ff;
            wdata     = bestval_ff;
            ptr_in    = '0;
            packed_in = '0;
            state_in  = S_PACK;
         end

         S_PACK: begin
            if (n == '0) begin
               rsp_valid_in       = 1'b1;
               rsp_in.perm_packed = '0;
               rsp_in.wrapped     = wrap_ff;
               state_in           = S_IDLE;
            end else begin
               if (issue) begin
                  ctl.rd_en = 1'b1;
                  ptr_in    = ptr_ff + CW'(1);
               end
               if (rd_vld_ff) begin
                  packed_in = packed_ff | pack_add;
                  if (rd_last) begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.perm_packed = packed_in;
                     rsp_in.wrapped     = wrap_ff;
                     state_in           = S_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rd_vld_in  = ctl.rd_en;
      rd_addr_in = raddr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      rd_addr_ff <= rd_addr_in;
      pivot_ff   <= pivot_in;
      found_ff   <= found_in;
      prev_ff    <= prev_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      tmp_ff     <= tmp_in;
      best_ok_ff <= best_ok_in;
      best_ff    <= best_in;
      bestval_ff <= bestval_in;
      wrap_ff    <= wrap_in;
      packed_ff  <= packed_in;
      rsp_ff     <= rsp_in;
   end

   `NPG_ASSERT(a_start_busy, clock, reset, (start && !busy) |=> busy, "accepted command left engine idle")
   `NPG_ASSERT(a_rsp_pulse, clock, reset, rsp_valid_ff |=> !rsp_valid_ff, "response strobe held two cycles")
   `NPG_ASSERT(a_no_rw_hit, clock, reset, !(ctl.rd_en && ctl.wr_en && (raddr == waddr)), "read and write hit one entry")
   `NPG_ASSERT(a_rev_span, clock, reset, (state_ff == S_REV_WR_LO) |-> (lo_ff < hi_ff), "reversal write outside span")

endmodule

/* src/next_permutation_generator.sv */
// Top level of the next permutation generator: order register, order clamp, engine.
// Depends on npg_pkg and npg_engine (which holds npg_elem_mem).
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+--------------------------
//   request  | in        | start / busy            | req_data  (cmd, index, value)
//   response | out       | rsp_valid (1-cycle)     | rsp_data  (perm_packed, wrapped)
//   csr      | in        | csr_valid / csr_ready   | csr_data  (order)
//
// A request transaction completes at a rising edge with start high and busy low.
// Every command returns one response transaction, shown for one cycle under rsp_valid;
// the receiver cannot stall it. The next command may be accepted in that same cycle.
// All passes read the element store through its single read port. Restart, load and the
// unused code run only the pack pass; advance with an order above one runs a scan, a
// suffix reversal, a suffix search, a swap and a pack pass. If the scan finds no ascent,
// advance wraps and goes from the reversal straight to the pack pass.
// Reset (synchronous, active high) returns the order to 8 and marks every element
// unwritten, so the store reads as identity at once; no clearing pass.
// csr_ready is low while a command is in flight or being issued.
module next_permutation_generator
   import npg_pkg::*;
#(
   parameter int MAX_ORDER = MAX_ORDER_DEFAULT,
   parameter int ELEM_BITS = ELEM_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  npg_req_type        req_data,
   output logic               rsp_valid,
   output npg_rsp_type        rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [ORDER_W-1:0] csr_data
);

   localparam int CW = $clog2(MAX_ORDER + 1);

   logic [ORDER_W-1:0] order_ff, order_in;
   logic [CW-1:0]      n_active;

   // order register, written only between commands
   assign csr_ready = !busy && !start;
   assign order_in  = (csr_valid && csr_ready) ? csr_data : order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
      end else begin
         order_ff <= order_in;
      end
   end

   // orders past the store depth behave as full depth
   always_comb begin
      if (int'(order_ff) > MAX_ORDER) begin
         n_active = CW'(MAX_ORDER);
      end else begin
         n_active = CW'(order_ff);
      end
   end

   npg_engine #(
      .MAX_ORDER (MAX_ORDER),
      .ELEM_BITS (ELEM_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .n         (n_active),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule
